// ----- hw/rtl/indexed_sequence_list_top_assert.svh -----
// Assertion macros for the indexed sequence list checker.
// Used by isl_checker.sv; expects clk_i and rst_ni in scope.
`ifndef INDEXED_SEQUENCE_LIST_TOP_ASSERT_SVH
`define INDEXED_SEQUENCE_LIST_TOP_ASSERT_SVH

// Condition holds in the same cycle as the trigger
`define ISL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Condition holds in the cycle after the trigger
`define ISL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

// ----- hw/rtl/isl_pkg.sv -----
// Package for the indexed sequence list: sizes, action and status codes,
// item structs and the command struct passed to the cells. No dependencies.
package isl_pkg;

  localparam int CAPACITY  = 16;
  localparam int WORD_BITS = 32;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int COUNT_W   = $clog2(CAPACITY + 1);

  // Action codes
  localparam logic [2:0] ACT_INS_FRONT = 3'd0;
  localparam logic [2:0] ACT_INS_BACK  = 3'd1;
  localparam logic [2:0] ACT_INS_AT    = 3'd2;
  localparam logic [2:0] ACT_REM_FRONT = 3'd3;
  localparam logic [2:0] ACT_REM_BACK  = 3'd4;
  localparam logic [2:0] ACT_READ      = 3'd5;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] value;
    logic [3:0]  position;
  } req_t;

  typedef struct packed {
    logic [31:0] read_word;
    logic        found;
    logic [1:0]  status;
    logic [4:0]  count;
  } rsp_t;

  // Per-cycle command broadcast along the chain
  typedef struct packed {
    logic             ins;
    logic             rem;
    logic [IDX_W-1:0] ins_pos;
    logic [IDX_W-1:0] rd_pos;
  } cell_cmd_t;

endpackage

// ----- hw/rtl/indexed_sequence_list_top.sv -----
// Indexed sequence list: bounded ordered list of words held in a chain of
// cells. Depends on isl_pkg and isl_cell.
//
// Usage:
//   Input channel in_valid_i / in_stall_o / in_req_i carries one request
//   item: action, value, position. Output channel out_valid_o / out_stall_i /
//   out_rsp_o carries one result item per request: read word, found flag,
//   status and the count after the request.
//   Every action finishes in the cycle it is accepted: all cells compare
//   their index with the insert or read position and shift in parallel, so
//   the result appears in the output register in the cycle after acceptance.
//   Throughput is one item per cycle while the receiver keeps taking results.
//   A held result stalls the input; a new item is taken in the same cycle
//   that the waiting result is taken.
//   Reset empties the list and drops any pending result; stored words are
//   not cleared, entries beyond the count are never read.
//   Inserts into a full list and removals from an empty list are reported
//   and leave the list unchanged.
module indexed_sequence_list_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  isl_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output isl_pkg::rsp_t out_rsp_o
);
  import isl_pkg::*;

  logic                 accept;
  logic [COUNT_W-1:0]   count_q, count_d;
  logic                 out_valid_q;
  rsp_t                 rsp_q, rsp_d;
  cell_cmd_t            cmd;
  logic                 ins_ok, rem_front_ok, full, empty, rd_hit, pos_past;
  logic [1:0]           status;
  logic [WORD_BITS-1:0] value_w;
  logic [WORD_BITS-1:0] words   [CAPACITY];
  logic [WORD_BITS-1:0] rd_bus  [CAPACITY];
  logic [WORD_BITS-1:0] left_w  [CAPACITY];
  logic [WORD_BITS-1:0] right_w [CAPACITY];
  logic [WORD_BITS-1:0] rd_word;

  // Stall input while a result waits
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign full     = (count_q == COUNT_W'(CAPACITY));
  assign empty    = (count_q == '0);
  assign rd_hit   = (32'(in_req_i.position) < 32'(count_q));
  assign pos_past = (32'(in_req_i.position) >= 32'(count_q));
  assign value_w  = WORD_BITS'(in_req_i.value);

  // Decode the action into status, count update and cell command
  always_comb begin
    status       = ST_OK;
    ins_ok       = 1'b0;
    rem_front_ok = 1'b0;
    count_d      = count_q;
    cmd.ins_pos  = '0;
    cmd.rd_pos   = IDX_W'(in_req_i.position);
    case (in_req_i.action)
      ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_AT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          ins_ok  = 1'b1;
          count_d = count_q + 1'b1;
          if (in_req_i.action == ACT_INS_FRONT) begin
            cmd.ins_pos = '0;
          end else if ((in_req_i.action == ACT_INS_BACK) || pos_past) begin
            cmd.ins_pos = IDX_W'(count_q);
          end else begin
            cmd.ins_pos = IDX_W'(in_req_i.position);
          end
        end
      end
      ACT_REM_FRONT, ACT_REM_BACK: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          rem_front_ok = (in_req_i.action == ACT_REM_FRONT);
          count_d      = count_q - 1'b1;
        end
      end
      ACT_READ: begin
        if (!rd_hit) begin
          status = ST_RANGE;
        end
      end
      default: begin
      end
    endcase
    cmd.ins = accept && ins_ok;
    cmd.rem = accept && rem_front_ok;
  end

  // Chain of cells, each wired to its neighbours
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign left_w[g] = '0;
    end else begin : g_mid_l
      assign left_w[g] = words[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_w[g] = '0;
    end else begin : g_mid_r
      assign right_w[g] = words[g+1];
    end

    isl_cell u_cell (
      .clk_i     (clk_i),
      .idx_i     (IDX_W'(g)),
      .cmd_i     (cmd),
      .value_i   (value_w),
      .left_i    (left_w[g]),
      .right_i   (right_w[g]),
      .word_o    (words[g]),
      .rd_word_o (rd_bus[g])
    );
  end

  // Merge the read bus of all cells
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_word = rd_word | rd_bus[i];
    end
  end

  // Assemble the result item
  always_comb begin
    rsp_d.found     = (in_req_i.action == ACT_READ) && rd_hit;
    rsp_d.read_word = rsp_d.found ? 32'(rd_word) : '0;
    rsp_d.status    = status;
    rsp_d.count     = 5'(count_d);
  end

  // Hold count and result; advance on acceptance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

endmodule

// ----- hw/rtl/isl_cell.sv -----
// One storage cell of the list chain: holds a word, shifts it to or from
// its neighbours on insert or front removal. Depends on isl_pkg.
module isl_cell (
  input  logic                            clk_i,
  input  logic [isl_pkg::IDX_W-1:0]       idx_i,
  input  isl_pkg::cell_cmd_t              cmd_i,
  input  logic [isl_pkg::WORD_BITS-1:0]   value_i,
  input  logic [isl_pkg::WORD_BITS-1:0]   left_i,
  input  logic [isl_pkg::WORD_BITS-1:0]   right_i,
  output logic [isl_pkg::WORD_BITS-1:0]   word_o,
  output logic [isl_pkg::WORD_BITS-1:0]   rd_word_o
);
  import isl_pkg::*;

  logic [WORD_BITS-1:0] word_q, word_d;

  // Take from the left above the insert point, load at it, pull from the
  // right on front removal, else hold
  always_comb begin
    word_d = word_q;
    if (cmd_i.ins && (idx_i > cmd_i.ins_pos)) begin
      word_d = left_i;
    end else if (cmd_i.ins && (idx_i == cmd_i.ins_pos)) begin
      word_d = value_i;
    end else if (cmd_i.rem) begin
      word_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o    = word_q;
  // Drive the word onto the read bus only when this cell is addressed
  assign rd_word_o = (idx_i == cmd_i.rd_pos) ? word_q : '0;

endmodule

// ----- hw/rtl/isl_checker.sv -----
// Port-level checker for the indexed sequence list, bound to the top level.
// Depends on isl_pkg and indexed_sequence_list_top_assert.svh.
`include "indexed_sequence_list_top_assert.svh"

module isl_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input isl_pkg::req_t in_req_i,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input isl_pkg::rsp_t out_rsp_o
);
  import isl_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // A stalled result holds
  `ISL_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_rsp_o))

  // Every accepted item gives a result in the next cycle
  `ISL_ASSERT_NEXT(a_result_follows, in_acc, out_valid_o)

  // A read reports either a hit or out of range
  `ISL_ASSERT_NEXT(a_read_status, in_acc && (in_req_i.action == ACT_READ), (out_rsp_o.found && (out_rsp_o.status == ST_OK)) || (!out_rsp_o.found && (out_rsp_o.status == ST_RANGE)))

  // A full report only comes with a full list
  `ISL_ASSERT_NOW(a_full_count, out_valid_o && (out_rsp_o.status == ST_FULL), out_rsp_o.count == 5'(CAPACITY))

endmodule

bind indexed_sequence_list_top isl_checker u_isl_checker (.*);

// ----- tb/sv/indexed_sequence_list_top_tb.sv -----
// Self-checking testbench for indexed_sequence_list_top: drives request items
// with random gaps and back-pressure and checks every result against a shadow list.
// Depends on isl_pkg and the indexed_sequence_list_top RTL.
module indexed_sequence_list_top_tb;
  import isl_pkg::*;

  // Action codes that the block treats as no operation
  localparam logic [2:0] ACT_NOP_LO = 3'd6;
  localparam logic [2:0] ACT_NOP_HI = 3'd7;
  localparam int RANDOM_ITEMS = 650;

  // Shadow of the list contents and the queue of results still owed
  class list_scoreboard;
    logic [WORD_BITS-1:0] words[$];
    rsp_t owed[$];
    int mismatches = 0;

    task report(string msg);
      $display("mismatch: %s", msg);
      mismatches++;
    endtask

    // Apply one request to the shadow list and return the result it gives
    function rsp_t predict_response(req_t r);
      rsp_t rsp;
      int slot;
      rsp = '0;
      rsp.status = ST_OK;
      case (r.action)
        ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_AT: begin
          if (words.size() >= CAPACITY) begin
            rsp.status = ST_FULL;
          end else begin
            if (r.action == ACT_INS_FRONT) slot = 0;
            else if (r.action == ACT_INS_BACK || r.position >= words.size()) slot = words.size();
            else slot = r.position;
            words.insert(slot, r.value);
          end
        end
        ACT_REM_FRONT: begin
          if (words.size() == 0) rsp.status = ST_EMPTY;
          else void'(words.pop_front());
        end
        ACT_REM_BACK: begin
          if (words.size() == 0) rsp.status = ST_EMPTY;
          else void'(words.pop_back());
        end
        ACT_READ: begin
          if (r.position < words.size()) begin
            rsp.read_word = words[r.position];
            rsp.found     = 1'b1;
          end else begin
            rsp.status = ST_RANGE;
          end
        end
        default: ;
      endcase
      rsp.count = 5'(words.size());
      return rsp;
    endfunction

    function void take_request(req_t r);
      owed.push_back(predict_response(r));
    endfunction

    task match_response(rsp_t got);
      rsp_t want;
      if (owed.size() == 0) begin
        report($sformatf("result with nothing owed: %p", got));
      end else begin
        want = owed.pop_front();
        if (got.read_word !== want.read_word)
          report($sformatf("read_word %h, want %h", got.read_word, want.read_word));
        if (got.found !== want.found)
          report($sformatf("found %b, want %b", got.found, want.found));
        if (got.status !== want.status)
          report($sformatf("status %0d, want %0d", got.status, want.status));
        if (got.count !== want.count)
          report($sformatf("count %0d, want %0d", got.count, want.count));
      end
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  req_t in_req_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  rsp_t out_rsp_o;

  int in_idle_pct = 35;
  int out_stall_pct = 35;
  bit filling = 1'b1;
  list_scoreboard sb = new();

  indexed_sequence_list_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Stall the result channel at random
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < out_stall_pct);
  end

  // Note accepted request items
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) sb.take_request(in_req_i);
  end

  // Check accepted result items
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.match_response(out_rsp_o);
  end

  // Offer one item after a random gap; return at the falling edge after acceptance
  task automatic send_request(input logic [2:0] act, input logic [31:0] val,
                              input logic [3:0] pos);
    req_t r;
    r.action   = act;
    r.value    = val;
    r.position = pos;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_req_i   <= r;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // Draw one request, leaning towards inserts while filling and removes while draining
  task automatic send_random();
    int held;
    int pick;
    logic [2:0] act;
    logic [31:0] val;
    logic [3:0] pos;
    held = sb.words.size();
    if (held >= CAPACITY && $urandom_range(9) < 3) filling = 1'b0;
    if (held == 0 && $urandom_range(9) < 3) filling = 1'b1;
    case ($urandom_range(7))
      0: val = '0;
      1: val = '1;
      default: val = $urandom();
    endcase
    pos  = 4'($urandom_range(15));
    pick = $urandom_range(99);
    if (pick < 6) begin
      act = pick[0] ? ACT_NOP_HI : ACT_NOP_LO;
    end else if (pick < 28) begin
      act = ACT_READ;
      if (held > 0 && $urandom_range(3) != 0) pos = 4'($urandom_range(held - 1));
    end else if ($urandom_range(99) < (filling ? 70 : 30)) begin
      case ($urandom_range(2))
        0: act = ACT_INS_FRONT;
        1: act = ACT_INS_BACK;
        default: act = ACT_INS_AT;
      endcase
    end else begin
      act = $urandom_range(1) ? ACT_REM_FRONT : ACT_REM_BACK;
    end
    send_request(act, val, pos);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Empty list: read out of range, removes rejected, unused codes do nothing
    send_request(ACT_READ, 32'h0, 4'd0);
    send_request(ACT_REM_FRONT, 32'h0, 4'd0);
    send_request(ACT_REM_BACK, 32'h0, 4'd0);
    send_request(ACT_NOP_LO, 32'hFFFF_FFFF, 4'd15);
    send_request(ACT_NOP_HI, 32'h0, 4'd0);
    // Insert and remove the only element from either end
    send_request(ACT_INS_FRONT, 32'hFFFF_FFFF, 4'd15);
    send_request(ACT_READ, 32'h0, 4'd0);
    send_request(ACT_REM_FRONT, 32'h0, 4'd0);
    send_request(ACT_INS_BACK, 32'h0, 4'd0);
    send_request(ACT_REM_BACK, 32'h0, 4'd0);
    // Fill to capacity; a position past the count appends
    send_request(ACT_INS_AT, 32'hA5A5_A5A5, 4'd15);
    for (int k = 1; k < CAPACITY; k++) begin
      case (k % 3)
        0: send_request(ACT_INS_FRONT, $urandom(), 4'd0);
        1: send_request(ACT_INS_BACK, $urandom(), 4'd0);
        default: send_request(ACT_INS_AT, $urandom(), k[3:0] >> 1);
      endcase
    end
    // Full list: inserts rejected, read the last and first slots
    send_request(ACT_INS_BACK, 32'h1234_5678, 4'd0);
    send_request(ACT_INS_AT, 32'h8765_4321, 4'd3);
    send_request(ACT_READ, 32'h0, 4'd15);
    send_request(ACT_READ, 32'h0, 4'd0);

    // Random traffic with one stretch free of gaps and stalls
    filling = 1'b0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      in_idle_pct   = (n >= 250 && n < 370) ? 0 : 35;
      out_stall_pct = in_idle_pct;
      send_random();
    end
    in_valid_i <= 1'b0;

    // Drain, then allow for any stray result
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.owed.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Abandon a hung run
  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
